// ===== sv/hcb_pkg.sv =====
// shared types and constants for the hex cell binning block
package hcb_pkg;
   localparam int MaxCells = 256;
   localparam int IdW = $clog2(MaxCells);
   localparam int DivW = 64;
   localparam logic [30:0] Sqrt3Q30 = 31'd1859775393;
   localparam logic [23:0] RadiusReset = 24'd25600;

   typedef struct packed {
      logic load;
      logic div_start;
      logic round_go;
      logic ctr_go;
      logic search_clr;
      logic search_step;
      logic rd_go;
      logic write_new;
      logic write_hit;
      logic result_go;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic ovf;
      logic search_end;
      logic hit;
      logic ctr_done;
      logic full;
   } sts_type;
endpackage

// ===== sv/hcb_ram.sv =====
// generic single-port ram with registered read
module hcb_ram #(
   parameter int Width = 16,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_ff <= mem_ff[addr];
   end

   assign rd_data = rd_ff;
endmodule

// ===== sv/hcb_div.sv =====
// restoring signed divider, one quotient bit per cycle, truncating
module hcb_div
   import hcb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic signed [DivW-1:0] dividend,
   input  logic [DivW-1:0]        divisor,
   output logic                   done,
   output logic signed [DivW-1:0] quotient
);
   localparam int CntW = $clog2(DivW + 1);
   logic [DivW-1:0] rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [DivW:0]   trial;
   logic [DivW-1:0] shl;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shl = {rem_ff[DivW-2:0], quo_ff[DivW-1]};
      trial = {1'b0, shl} - {1'b0, dvs_ff};
      if (start) begin
         neg_in = dividend[DivW-1];
         quo_in = dividend[DivW-1] ? -dividend : dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CntW'(DivW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff[DivW-1] || !trial[DivW]) begin
            rem_in = rem_ff[DivW-1] ? (shl - dvs_ff) : trial[DivW-1:0];
            quo_in = {quo_ff[DivW-2:0], 1'b1};
         end else begin
            rem_in = shl;
            quo_in = {quo_ff[DivW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quotient = neg_ff ? -quo_ff : quo_ff;
endmodule

// ===== sv/hcb_datapath.sv =====
// datapath: scaling, division, cube rounding, centre, cell table
module hcb_datapath
   import hcb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  hcb_pkg::cmd_type    cmd,
   output hcb_pkg::sts_type    sts,
   input  logic [23:0]         radius,
   input  logic signed [31:0]  x_pos,
   input  logic signed [31:0]  y_pos,
   output logic [7:0]          cell_id,
   output logic signed [15:0]  cell_q,
   output logic signed [15:0]  cell_r,
   output logic signed [31:0]  center_x,
   output logic signed [31:0]  center_y,
   output logic                new_cell,
   output logic [15:0]         member_count,
   output logic                table_full,
   output logic                coord_overflow
);
   logic signed [31:0] x_ff, y_ff;
   logic [23:0]        rad_ff;
   logic [DivW-1:0]    dvs_ff;
   logic signed [63:0] kx_ff, num_ff;
   logic signed [63:0] fq_ff, fr_ff;
   logic               dv_start, dv_done;
   logic signed [63:0] dv_q;
   logic [1:0]         ph_ff;
   logic signed [15:0] q_ff, r_ff;
   logic               ovf_ff;
   logic [IdW:0]       next_ff, idx_ff;
   logic [MaxCells-1:0] valid_ff;
   logic               hit_ff, full_ff, newc_ff;
   logic [IdW-1:0]     id_ff, addr;
   logic [15:0]        cnt_ff;
   logic [15:0]        rq_rd, rr_rd, mc_rd, mc_wr;
   logic               key_we, mc_we;
   logic [1:0]         cs_ff;
   logic signed [63:0] cy_ff, cxt_ff;
   logic [63:0]        acc_ff;
   logic [42:0]        mag_ff;
   logic               cneg_ff;

   // fractional coordinates, round and fix up
   logic signed [63:0] rq, rr, rs, fs, dq, dr, ds, fq_r, fr_r;
   logic signed [63:0] q_sel, r_sel;

   function automatic logic signed [63:0] rnd(input logic signed [63:0] v);
      logic [63:0] m;
      m = v[63] ? -v : v;
      m = (m + 64'd32768) >>> 16;
      return v[63] ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [63:0] abs64(input logic signed [63:0] v);
      return v[63] ? -v : v;
   endfunction

   always_comb begin
      fq_r = fq_ff;
      fr_r = fr_ff;
      fs = -fq_r - fr_r;
      rq = rnd(fq_r);
      rr = rnd(fr_r);
      rs = rnd(fs);
      dq = abs64((rq <<< 16) - fq_r);
      dr = abs64((rr <<< 16) - fr_r);
      ds = abs64((rs <<< 16) - fs);
      q_sel = rq;
      r_sel = rr;
      if (dq > dr && dq > ds) begin
         q_sel = -rr - rs;
      end else if (dr > ds) begin
         r_sel = -rq - rs;
      end
   end

   assign dv_start = cmd.div_start || (dv_done && ph_ff == 2'd1);

   hcb_div u_div (
      .clock(clock), .reset(reset), .start(dv_start),
      .dividend((ph_ff == 2'd1) ? num_ff : kx_ff - (64'(y_ff) <<< 30)),
      .divisor(dvs_ff), .done(dv_done), .quotient(dv_q)
   );

   // table search / update address
   assign addr = cmd.write_new ? next_ff[IdW-1:0] :
                 ((cmd.write_hit || cmd.rd_go) ? id_ff : idx_ff[IdW-1:0]);
   assign key_we = cmd.write_new;
   assign mc_we  = cmd.write_new || cmd.write_hit;
   assign mc_wr  = cmd.write_new ? 16'd1 : ((mc_rd == 16'hFFFF) ? mc_rd : mc_rd + 16'd1);

   hcb_ram #(.Width(16), .Depth(MaxCells)) u_kq (
      .clock(clock), .wr_en(key_we), .addr(addr), .wr_data(q_ff), .rd_data(rq_rd));
   hcb_ram #(.Width(16), .Depth(MaxCells)) u_kr (
      .clock(clock), .wr_en(key_we), .addr(addr), .wr_data(r_ff), .rd_data(rr_rd));
   hcb_ram #(.Width(16), .Depth(MaxCells)) u_mc (
      .clock(clock), .wr_en(mc_we), .addr(addr), .wr_data(mc_wr), .rd_data(mc_rd));

   // compare uses the step flag and index registered alongside the ram read data
   logic               cmp_ff;
   logic [IdW-1:0]     cidx_ff;
   logic               cvalid;
   logic               step_ok;
   assign cvalid = valid_ff[cidx_ff];
   assign step_ok = cmd.search_step && idx_ff != (IdW+1)'(MaxCells);

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= '0;
         valid_ff <= '0;
         next_ff <= '0;
         hit_ff <= 1'b0;
         cmp_ff <= 1'b0;
         cs_ff <= '0;
      end else begin
         if (cmd.div_start) begin
            ph_ff <= 2'd1;
         end else if (dv_done) begin
            ph_ff <= (ph_ff == 2'd1) ? 2'd2 : 2'd0;
         end
         if (cmd.search_clr) begin
            hit_ff <= 1'b0;
            cmp_ff <= 1'b0;
         end else begin
            cmp_ff <= step_ok;
            if (cmp_ff && !hit_ff && cvalid && rq_rd == q_ff && rr_rd == r_ff) begin
               hit_ff <= 1'b1;
            end
         end
         if (cmd.write_new) begin
            valid_ff[next_ff[IdW-1:0]] <= 1'b1;
            next_ff <= next_ff + 1'b1;
         end
         if (cmd.ctr_go) begin
            cs_ff <= 2'd1;
         end else if (cs_ff != 2'd0) begin
            cs_ff <= (cs_ff == 2'd3) ? 2'd0 : cs_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff <= x_pos;
         y_ff <= y_pos;
         rad_ff <= (radius == '0) ? 24'd1 : radius;
         dvs_ff <= 64'((radius == '0) ? 24'd1 : radius) * 64'd49152;
      end
      kx_ff <= 64'(x_ff) * $signed({1'b0, Sqrt3Q30});
      num_ff <= 64'(y_ff) <<< 31;
      if (dv_done && ph_ff == 2'd1) begin
         fq_ff <= dv_q;
      end
      if (dv_done && ph_ff == 2'd2) begin
         fr_ff <= dv_q;
      end
      if (cmd.round_go) begin
         ovf_ff <= q_sel > 64'sd32767 || q_sel < -64'sd32768 ||
                   r_sel > 64'sd32767 || r_sel < -64'sd32768;
         q_ff <= (q_sel > 64'sd32767) ? 16'sh7FFF :
                 (q_sel < -64'sd32768) ? 16'sh8000 : q_sel[15:0];
         r_ff <= (r_sel > 64'sd32767) ? 16'sh7FFF :
                 (r_sel < -64'sd32768) ? 16'sh8000 : r_sel[15:0];
      end
      // centre: step 1 products, 2 magnitude and y halving, 3 split multiply
      if (cs_ff == 2'd1) begin
         cy_ff <= 64'($signed({1'b0, rad_ff})) * 64'(r_ff) * 64'sd3;
         cxt_ff <= 64'($signed({1'b0, rad_ff})) * (64'(q_ff) * 2 + 64'(r_ff));
      end
      if (cs_ff == 2'd2) begin
         cneg_ff <= cxt_ff[63];
         mag_ff <= 43'(cxt_ff[63] ? -cxt_ff : cxt_ff);
         cy_ff <= cy_ff[63] ? -64'($signed((64'(-cy_ff) + 64'd1) >> 1))
                            : 64'($signed((64'(cy_ff) + 64'd1) >> 1));
      end
      if (cs_ff == 2'd3) begin
         acc_ff <= 64'(mag_ff[42:20]) * 64'(Sqrt3Q30);
      end
      if (cmd.search_clr) begin
         idx_ff <= '0;
         cidx_ff <= '0;
         id_ff <= '0;
      end else if (cmd.result_go) begin
         if (cmd.write_new) begin
            id_ff <= next_ff[IdW-1:0];
         end else if (!cmd.write_hit) begin
            id_ff <= '0;
         end
      end else begin
         if (step_ok) begin
            idx_ff <= idx_ff + 1'b1;
            cidx_ff <= idx_ff[IdW-1:0];
         end
         if (cmp_ff && !hit_ff) begin
            id_ff <= cidx_ff;
         end
      end
      if (cmd.result_go) begin
         newc_ff <= cmd.write_new;
         if (cmd.write_new) begin
            cnt_ff <= 16'd1;
            full_ff <= 1'b0;
         end else if (cmd.write_hit) begin
            cnt_ff <= mc_wr;
            full_ff <= 1'b0;
         end else begin
            cnt_ff <= '0;
            full_ff <= !ovf_ff;
         end
      end
   end

   // centre x final combine (combinational from acc/mag)
   logic [63:0] low, res;
   always_comb begin
      low = ({52'd0, acc_ff[11:0]} << 20) + 64'(mag_ff[19:0]) * 64'(Sqrt3Q30)
            + 64'h80000000;
      res = (acc_ff >> 12) + (low >> 32);
      if (res > 64'h100000000) res = 64'h100000000;
   end

   logic signed [64:0] cxs;
   assign cxs = cneg_ff ? -$signed({1'b0, res}) : $signed({1'b0, res});

   assign sts.div_done   = dv_done && ph_ff == 2'd2;
   assign sts.ovf        = ovf_ff;
   assign sts.search_end = idx_ff == (IdW+1)'(MaxCells) && !cmp_ff;
   assign sts.hit        = hit_ff;
   assign sts.ctr_done   = cs_ff == 2'd0;
   assign sts.full       = next_ff == (IdW+1)'(MaxCells);

   assign cell_id = 8'(id_ff);
   assign cell_q = q_ff;
   assign cell_r = r_ff;
   assign center_y = (cy_ff > 64'sd2147483647) ? 32'sh7FFFFFFF :
                     (cy_ff < -64'sd2147483648) ? 32'sh80000000 : cy_ff[31:0];
   assign center_x = (cxs > 65'sd2147483647) ? 32'sh7FFFFFFF :
                     (cxs < -65'sd2147483648) ? 32'sh80000000 : cxs[31:0];
   assign new_cell = newc_ff;
   assign member_count = cnt_ff;
   assign table_full = full_ff;
   assign coord_overflow = ovf_ff;

   a_new_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.write_new |-> !sts.full)
      else $error("insert into full table");
   a_next_advance: assert property (@(posedge clock) disable iff (reset)
      cmd.write_new |=> next_ff == $past(next_ff) + 1'b1)
      else $error("next id not advanced");
   a_hit_update: assert property (@(posedge clock) disable iff (reset)
      cmd.write_hit |-> hit_ff)
      else $error("update without hit");
endmodule

// ===== sv/hcb_ctrl.sv =====
// controller state machine for the binning sequence
module hcb_ctrl
   import hcb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hcb_pkg::cmd_type cmd,
   input  hcb_pkg::sts_type sts
);
   localparam logic [2:0] StIdle = 3'd0, StStart = 3'd1, StDiv = 3'd2, StCtr = 3'd3,
                          StSearch = 3'd4, StDrain = 3'd5, StUpd = 3'd6, StOut = 3'd7;
   logic [2:0] st_ff, st_in;
   logic [1:0] wt_ff, wt_in;

   always_comb begin
      st_in = st_ff;
      wt_in = wt_ff;
      cmd = '0;
      unique case (st_ff)
         StIdle: if (req_valid) begin
            cmd.load = 1'b1;
            wt_in = 2'd2;
            st_in = StStart;
         end
         StStart: begin
            wt_in = wt_ff - 2'd1;
            if (wt_ff == 2'd1) begin
               cmd.div_start = 1'b1;
               st_in = StDiv;
            end
         end
         StDiv: if (sts.div_done) begin
            st_in = StCtr;
         end
         StCtr: begin
            if (wt_ff == 2'd0) begin
               cmd.round_go = 1'b1;
               wt_in = 2'd1;
            end else if (wt_ff == 2'd1) begin
               cmd.ctr_go = 1'b1;
               cmd.search_clr = 1'b1;
               wt_in = 2'd2;
            end else if (sts.ctr_done) begin
               wt_in = 2'd0;
               st_in = sts.ovf ? StUpd : StSearch;
            end
         end
         StSearch: begin
            if (sts.hit || sts.search_end) begin
               st_in = StDrain;
            end else begin
               cmd.search_step = 1'b1;
            end
         end
         StDrain: begin
            cmd.rd_go = 1'b1;
            st_in = StUpd;
         end
         StUpd: begin
            cmd.result_go = 1'b1;
            if (!sts.ovf) begin
               if (sts.hit) begin
                  cmd.write_hit = 1'b1;
               end else if (!sts.full) begin
                  cmd.write_new = 1'b1;
               end
            end
            st_in = StOut;
         end
         StOut: if (rsp_ready) begin
            st_in = StIdle;
         end
         default: st_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= StIdle;
         wt_ff <= '0;
      end else begin
         st_ff <= st_in;
         wt_ff <= wt_in;
      end
   end

   assign req_ready = st_ff == StIdle;
   assign rsp_valid = st_ff == StOut;
endmodule

// ===== sv/hex_cell_binning_with_id_table.sv =====
// top level: pointy-top hex cell binning with a sequential cell id table
// Usage notes:
//   req channel (req_valid/req_ready) transfers one node position x_pos, y_pos.
//   rsp channel (rsp_valid/rsp_ready) transfers one result per position:
//   cell id, axial q/r, cell centre, new-cell mark, member count and flags.
//   csr channel (csr_valid/csr_ready) writes the cell radius; always ready,
//   write only while idle.
//   Processing takes two 64-step serial divisions by 3*R*2^14, then the
//   linear key search through the table ram, which stops at the first hit.
//   A new key or a full table scans all 256 entries; when q or r overflows,
//   the search is skipped and the table is not accessed.
//   One item at a time: req_ready is high only when no item is in flight,
//   at the earliest in the cycle after the result transfer.
//   Reset empties the table (valid bits cleared, next id zero) and loads
//   the radius reset value of 100 m. No clearing pass is needed.
//   When the receiver stalls, the result is held on the rsp ports and no
//   new item is taken until it is transferred.
module hex_cell_binning_with_id_table (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_x_pos,
   input  logic signed [31:0] req_y_pos,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_cell_id,
   output logic signed [15:0] rsp_cell_q,
   output logic signed [15:0] rsp_cell_r,
   output logic signed [31:0] rsp_center_x,
   output logic signed [31:0] rsp_center_y,
   output logic               rsp_new_cell,
   output logic [15:0]        rsp_member_count,
   output logic               rsp_table_full,
   output logic               rsp_coord_overflow,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [23:0]        csr_cell_radius
);
   import hcb_pkg::*;
   cmd_type cmd;
   sts_type sts;
   logic [23:0] rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rad_ff <= RadiusReset;
      end else if (csr_valid && csr_ready) begin
         rad_ff <= csr_cell_radius;
      end
   end
   assign csr_ready = 1'b1;

   hcb_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .cmd(cmd), .sts(sts));

   hcb_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts), .radius(rad_ff),
      .x_pos(req_x_pos), .y_pos(req_y_pos), .cell_id(rsp_cell_id),
      .cell_q(rsp_cell_q), .cell_r(rsp_cell_r), .center_x(rsp_center_x),
      .center_y(rsp_center_y), .new_cell(rsp_new_cell),
      .member_count(rsp_member_count), .table_full(rsp_table_full),
      .coord_overflow(rsp_coord_overflow));
endmodule

// ===== tb/hex_cell_binning_with_id_table_tb.sv =====
// testbench for the hex cell binning block with its own cell table predictor
module hex_cell_binning_with_id_table_tb;
   import hcb_pkg::*;

   localparam longint Sqrt3K = 64'd1859775393;
   localparam int CycleLimit = 4000000;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
   } position_t;

   typedef struct packed {
      logic [7:0]         id;
      logic signed [15:0] q;
      logic signed [15:0] r;
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic               new_cell;
      logic [15:0]        count;
      logic               full;
      logic               ovf;
   } cell_result_t;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic signed [31:0] req_x_pos = 0;
   logic signed [31:0] req_y_pos = 0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic [7:0]         rsp_cell_id;
   logic signed [15:0] rsp_cell_q;
   logic signed [15:0] rsp_cell_r;
   logic signed [31:0] rsp_center_x;
   logic signed [31:0] rsp_center_y;
   logic               rsp_new_cell;
   logic [15:0]        rsp_member_count;
   logic               rsp_table_full;
   logic               rsp_coord_overflow;
   logic               csr_valid = 0;
   logic               csr_ready;
   logic [23:0]        csr_cell_radius = 0;

   position_t    pending_positions[$];
   position_t    sent_history[$];
   cell_result_t expected_cells[$];

   logic [23:0]  radius_shadow = RadiusReset;
   logic signed [15:0] table_q[MaxCells];
   logic signed [15:0] table_r[MaxCells];
   logic         table_used[MaxCells];
   logic [15:0]  table_count[MaxCells];
   int           next_cell_id = 0;

   int  errors = 0;
   int  cycles = 0;
   int  cells_seen = 0;
   int  hold_left = 0;
   bit  hold_done = 0;
   bit  req_fire = 0;

   hex_cell_binning_with_id_table dut (.*);

   always #2 clock = ~clock;

   function automatic longint round_half_away(input longint v);
      if (v < 0) return -((-v + 32768) >>> 16);
      return (v + 32768) >>> 16;
   endfunction

   function automatic longint abs_l(input longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint scale_sqrt3_half(input longint t);
      longint unsigned m, th, tl, acc, low, res;
      m = abs_l(t);
      th = m >> 20;
      tl = m & 64'hFFFFF;
      acc = th * Sqrt3K;
      low = ((acc & 64'hFFF) << 20) + tl * Sqrt3K + 64'h80000000;
      res = (acc >> 12) + (low >> 32);
      if (res > 64'h100000000) res = 64'h100000000;
      return t < 0 ? -longint'(res) : longint'(res);
   endfunction

   function automatic cell_result_t bin_position(input logic signed [31:0] xp,
                                                 input logic signed [31:0] yp);
      cell_result_t o;
      longint x, y, rad, dv, fq, fr, fs, rq, rr, rs, dq, dr, ds, q, r, cy, cx;
      int hit;
      x = xp;
      y = yp;
      rad = radius_shadow == 0 ? 1 : longint'(radius_shadow);
      dv = 3 * rad * 16384;
      fq = (Sqrt3K * x - y * 64'sd1073741824) / dv;
      fr = (y * 64'sd2147483648) / dv;
      fs = -fq - fr;
      rq = round_half_away(fq);
      rr = round_half_away(fr);
      rs = round_half_away(fs);
      dq = abs_l(rq * 65536 - fq);
      dr = abs_l(rr * 65536 - fr);
      ds = abs_l(rs * 65536 - fs);
      if (dq > dr && dq > ds) rq = -rr - rs;
      else if (dr > ds) rr = -rq - rs;
      q = clamp(rq, -32768, 32767);
      r = clamp(rr, -32768, 32767);
      o = '0;
      o.q = 16'(q);
      o.r = 16'(r);
      o.ovf = (q != rq) || (r != rr);
      cy = 3 * rad * r;
      cy = cy < 0 ? -((-cy + 1) >>> 1) : ((cy + 1) >>> 1);
      o.cy = 32'(clamp(cy, -64'sd2147483648, 64'sd2147483647));
      cx = scale_sqrt3_half(rad * (2 * q + r));
      o.cx = 32'(clamp(cx, -64'sd2147483648, 64'sd2147483647));
      if (!o.ovf) begin
         hit = -1;
         for (int i = 0; i < MaxCells; i++)
            if (hit < 0 && table_used[i] && table_q[i] == o.q && table_r[i] == o.r) hit = i;
         if (hit >= 0) begin
            if (table_count[hit] != 16'hFFFF) table_count[hit]++;
            o.id = 8'(hit);
            o.count = table_count[hit];
         end else if (next_cell_id < MaxCells) begin
            table_q[next_cell_id] = o.q;
            table_r[next_cell_id] = o.r;
            table_used[next_cell_id] = 1'b1;
            table_count[next_cell_id] = 16'd1;
            o.id = 8'(next_cell_id);
            o.count = 16'd1;
            o.new_cell = 1'b1;
            next_cell_id++;
         end else begin
            o.full = 1'b1;
         end
      end
      return o;
   endfunction

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   // predictor and result checker
   always @(posedge clock) begin
      cell_result_t e;
      cycles++;
      if (cycles > CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end else if (!reset) begin
         req_fire <= req_valid && req_ready;
         if (csr_valid && csr_ready) radius_shadow = csr_cell_radius;
         if (req_valid && req_ready)
            expected_cells.insert(expected_cells.size(), bin_position(req_x_pos, req_y_pos));
         if (rsp_valid && rsp_ready) begin
            cells_seen++;
            if (expected_cells.size() == 0) begin
               $error("result transfer with nothing expected");
               errors++;
            end else begin
               e = expected_cells.pop_front();
               check_field("cell_id", e.id, rsp_cell_id);
               check_field("cell_q", e.q, rsp_cell_q);
               check_field("cell_r", e.r, rsp_cell_r);
               check_field("center_x", e.cx, rsp_center_x);
               check_field("center_y", e.cy, rsp_center_y);
               check_field("new_cell", e.new_cell, rsp_new_cell);
               check_field("member_count", e.count, rsp_member_count);
               check_field("table_full", e.full, rsp_table_full);
               check_field("coord_overflow", e.ovf, rsp_coord_overflow);
            end
         end
      end
   end

   // driver
   always @(negedge clock) begin
      bit quiet;
      quiet = cycles > 100000 && cycles < 200000;
      if (reset) begin
         req_valid <= 0;
      end else if (!req_valid || req_fire) begin
         if (pending_positions.size() > 0 && (quiet || $urandom_range(0, 99) >= 16)) begin
            position_t p;
            p = pending_positions.pop_front();
            req_valid <= 1;
            req_x_pos <= p.x;
            req_y_pos <= p.y;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // receiver with one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else if (hold_left > 0) begin
         rsp_ready <= 0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && cells_seen == 200) begin
         hold_done <= 1;
         hold_left <= 3000;
         rsp_ready <= 0;
      end else if (cycles > 100000 && cycles < 200000) begin
         rsp_ready <= 1;
      end else begin
         rsp_ready <= $urandom_range(0, 99) >= 16;
      end
   end

   function automatic logic signed [31:0] near_coord(input longint span);
      return $signed(32'(longint'($urandom_range(0, 32'(2 * span))) - span));
   endfunction

   task automatic queue_position(input logic signed [31:0] x, input logic signed [31:0] y);
      position_t p;
      p.x = x;
      p.y = y;
      pending_positions.insert(pending_positions.size(), p);
      sent_history.insert(sent_history.size(), p);
   endtask

   task automatic queue_random(input int n);
      longint span;
      int pick;
      position_t p;
      span = (radius_shadow == 0 ? 1 : longint'(radius_shadow)) * 6 + 16;
      if (span > 64'sd1000000000) span = 64'sd1000000000;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            queue_position(near_coord(span), near_coord(span));
         end else if (pick < 70 && sent_history.size() > 0) begin
            p = sent_history[$urandom_range(0, sent_history.size() - 1)];
            pending_positions.insert(pending_positions.size(), p);
         end else if (pick < 88) begin
            queue_position($urandom, $urandom);
         end else begin
            queue_position({$urandom_range(0, 1) ? 2'b01 : 2'b10, 30'($urandom)},
                           {$urandom_range(0, 1) ? 2'b01 : 2'b10, 30'($urandom)});
         end
      end
   endtask

   task automatic wait_drained;
      while (pending_positions.size() > 0 || req_valid || expected_cells.size() > 0)
         @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_radius(input logic [23:0] v);
      @(negedge clock);
      csr_valid <= 1;
      csr_cell_radius <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   initial begin
      logic [23:0] radii[8];
      for (int i = 0; i < MaxCells; i++) table_used[i] = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      queue_position(0, 0);
      queue_position(32'sh7FFFFFFF, 32'sh7FFFFFFF);
      queue_position(32'sh80000000, 32'sh80000000);
      queue_position(32'sh7FFFFFFF, 32'sh80000000);
      queue_position(32'sh80000000, 32'sh7FFFFFFF);
      queue_position(0, 32'sh7FFFFFFF);
      queue_position(0, 32'sh80000000);
      queue_position(32'sh7FFFFFFF, 0);
      queue_position(32'sh80000000, 0);
      queue_position(1, -1);
      queue_position(-1, 1);
      queue_position(0, 0);
      queue_position(22170, 12800);
      queue_position(-22170, -12800);
      queue_position(44340, 0);
      queue_position(0, 0);
      queue_random(40);
      wait_drained();

      radii = '{24'd1, 24'hFFFFFF, 24'd0, 24'd256, 24'd25600, 24'd7, 24'd3000, 24'd90};
      radii[6] = 24'($urandom_range(2, 24'hFFFFFE));
      for (int ph = 0; ph < 8; ph++) begin
         write_radius(radii[ph]);
         wait_drained();
         if (ph == 0) begin
            queue_position(0, 0);
            queue_position(1, 1);
            queue_position(32'sh7FFFFFFF, 32'sh7FFFFFFF);
            queue_position(32'sh80000000, 0);
         end
         queue_random(215);
         wait_drained();
      end

      repeat (600) @(negedge clock);
      if (errors == 0 && expected_cells.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
